[hdl/dsc_pkg.sv]
// Shared types and constants for the day number to calendar converter.
// Holds the transfer structs, the calendar constants and the month start table.
// Depends on nothing.
package dsc_pkg;

   // Width of the day number and of the tick count.
   localparam int DAY_BITS  = 17;
   localparam int TICK_BITS = 25;

   // Time of day constants, in ticks of 1/300 second.
   localparam int TICKS_PER_DAY  = 25920000;
   localparam int TICKS_PER_HOUR = 1080000;
   localparam int TICKS_PER_MIN  = 18000;
   localparam int TICKS_PER_SEC  = 300;

   // Calendar constants. The date math counts from 1600-03-01, the start of a
   // 400 year cycle with March as the first month; 1900-01-01 lies this many
   // days after it.
   localparam int EPOCH_OFFSET   = 109513;
   localparam int ERA_DAYS       = 146097;
   localparam int QUAD_DAYS      = 1460;
   localparam int CENTURY_DAYS   = 36524;
   localparam int ERA_LAST_DAY   = 146096;
   localparam int YEAR_DAYS      = 365;
   localparam int CENTURY_YEARS  = 100;
   localparam int CYCLE_YEARS    = 400;
   localparam int BASE_YEAR      = 1600;
   localparam int MONTH_SPAN     = 153;
   localparam int MONTH_SCALE    = 5;
   localparam int MONTH_ROUND    = 2;
   // Months are counted from March; this index is January.
   localparam int MP_JANUARY     = 10;
   localparam int MARCH_NUMBER   = 3;
   localparam int JANUARY_SHIFT  = 9;

   typedef struct packed {
      logic [DAY_BITS-1:0]  day_number;
      logic [TICK_BITS-1:0] tick_of_day;
   } req_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        valid_res;
   } rsp_type;

   // Time of day fields once they are final.
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       ok;
   } tod_type;

   // Day of a March-based year on which each month starts.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start_day;
      case (mp)
         4'd0:    start_day = 9'd0;
         4'd1:    start_day = 9'd31;
         4'd2:    start_day = 9'd61;
         4'd3:    start_day = 9'd92;
         4'd4:    start_day = 9'd122;
         4'd5:    start_day = 9'd153;
         4'd6:    start_day = 9'd184;
         4'd7:    start_day = 9'd214;
         4'd8:    start_day = 9'd245;
         4'd9:    start_day = 9'd275;
         4'd10:   start_day = 9'd306;
         4'd11:   start_day = 9'd337;
         default: start_day = 9'd0;
      endcase
      return start_day;
   endfunction

endpackage

[hdl/day_serial_to_calendar_fields.sv]
// Top level of the day number to calendar converter: a nine stage pipeline.
// Depends on dsc_pkg for the transfer structs, constants and month table.
//
// A transfer is taken at every clock edge where start is high and busy is low;
// busy is high only while reset is held, so one item can enter on every clock.
// Each result leaves after its transfer has passed every stage, for one cycle,
// with rsp_strobe high. The receiver cannot stall, and no stage ever waits.
// Throughput is one conversion per clock; the depth of the pipeline is set by the
// chain of constant divisions (cycle, century, year, month), each done as an
// exact reciprocal multiply, with a subtract for the remainder in a later stage.
// Tick counts of a full day or more give valid_res low and zero time fields.
module day_serial_to_calendar_fields
   import dsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int NSTG      = 9;
   localparam int ZB        = DAY_BITS + 1;
   localparam int ERA_BITS  = $clog2((2**ZB - 1) / ERA_DAYS + 1);
   localparam int DOE_BITS  = 18;
   localparam int REMH_BITS = 21;
   localparam int REMM_BITS = 15;
   localparam int YFB       = $clog2((2**ERA_BITS) * CYCLE_YEARS + 2 * BASE_YEAR);

   // Exact reciprocals: M = ceil(2^S / C) with 2^S >= 2^xbits * C.
   localparam int S_ERA = ZB + $clog2(ERA_DAYS);
   localparam longint unsigned M_ERA = ((64'd1 << S_ERA) + ERA_DAYS - 1) / ERA_DAYS;
   localparam int MB_ERA = $clog2(M_ERA + 1);

   localparam int S_HR = TICK_BITS + $clog2(TICKS_PER_HOUR);
   localparam longint unsigned M_HR =
      ((64'd1 << S_HR) + TICKS_PER_HOUR - 1) / TICKS_PER_HOUR;
   localparam int MB_HR = $clog2(M_HR + 1);

   localparam int S_Q4 = DOE_BITS + $clog2(QUAD_DAYS);
   localparam longint unsigned M_Q4 = ((64'd1 << S_Q4) + QUAD_DAYS - 1) / QUAD_DAYS;
   localparam int MB_Q4 = $clog2(M_Q4 + 1);

   localparam int S_C1 = DOE_BITS + $clog2(CENTURY_DAYS);
   localparam longint unsigned M_C1 =
      ((64'd1 << S_C1) + CENTURY_DAYS - 1) / CENTURY_DAYS;
   localparam int MB_C1 = $clog2(M_C1 + 1);

   localparam int S_MN = REMH_BITS + $clog2(TICKS_PER_MIN);
   localparam longint unsigned M_MN =
      ((64'd1 << S_MN) + TICKS_PER_MIN - 1) / TICKS_PER_MIN;
   localparam int MB_MN = $clog2(M_MN + 1);

   localparam int S_YR = DOE_BITS + $clog2(YEAR_DAYS);
   localparam longint unsigned M_YR = ((64'd1 << S_YR) + YEAR_DAYS - 1) / YEAR_DAYS;
   localparam int MB_YR = $clog2(M_YR + 1);

   localparam int S_SC = REMM_BITS + $clog2(TICKS_PER_SEC);
   localparam longint unsigned M_SC =
      ((64'd1 << S_SC) + TICKS_PER_SEC - 1) / TICKS_PER_SEC;
   localparam int MB_SC = $clog2(M_SC + 1);

   localparam int S_YC = 9 + $clog2(CENTURY_YEARS);
   localparam longint unsigned M_YC =
      ((64'd1 << S_YC) + CENTURY_YEARS - 1) / CENTURY_YEARS;
   localparam int MB_YC = $clog2(M_YC + 1);

   localparam int S_MP = 11 + $clog2(MONTH_SPAN);
   localparam longint unsigned M_MP = ((64'd1 << S_MP) + MONTH_SPAN - 1) / MONTH_SPAN;
   localparam int MB_MP = $clog2(M_MP + 1);

   logic            accept;
   logic [NSTG-1:0] vld_ff;

   // Stage 1: shift the day number to the cycle epoch, estimate cycle and hour.
   logic [ZB-1:0]          z1_in, z1_ff;
   logic [ZB+MB_ERA-1:0]   era_prod;
   logic [ERA_BITS-1:0]    era1_in, era1_ff;
   logic [TICK_BITS+MB_HR-1:0] hr_prod;
   logic [4:0]             hr1_in, hr1_ff;
   logic [TICK_BITS-1:0]   tk1_ff;
   logic                   ok1_in, ok1_ff;

   // Stage 2: day of cycle and ticks within the hour.
   logic [ERA_BITS-1:0]    era2_ff;
   logic [DOE_BITS-1:0]    doe2_in, doe2_ff;
   logic [4:0]             hr2_ff;
   logic [REMH_BITS-1:0]   rem2_in, rem2_ff;
   logic                   ok2_ff;

   // Stage 3: four-year and century counts, minute.
   logic [ERA_BITS-1:0]    era3_ff;
   logic [DOE_BITS-1:0]    doe3_ff;
   logic [DOE_BITS+MB_Q4-1:0] q4_prod;
   logic [DOE_BITS+MB_C1-1:0] c1_prod;
   logic [6:0]             q4_3_in, q4_3_ff;
   logic [2:0]             c1_3_in, c1_3_ff;
   logic                   last3_in, last3_ff;
   logic [4:0]             hr3_ff;
   logic [REMH_BITS-1:0]   rem3_ff;
   logic [REMH_BITS+MB_MN-1:0] mn_prod;
   logic [5:0]             mn3_in, mn3_ff;
   logic                   ok3_ff;

   // Stage 4: day count with the leap days taken out, ticks within the minute.
   logic [ERA_BITS-1:0]    era4_ff;
   logic [DOE_BITS-1:0]    doe4_ff;
   logic [DOE_BITS-1:0]    yn4_in, yn4_ff;
   logic [4:0]             hr4_ff;
   logic [5:0]             mn4_ff;
   logic [REMM_BITS-1:0]   rem4_in, rem4_ff;
   logic                   ok4_ff;

   // Stage 5: year of cycle, second; time of day is final here.
   logic [ERA_BITS-1:0]    era5_ff;
   logic [DOE_BITS-1:0]    doe5_ff;
   logic [DOE_BITS+MB_YR-1:0] yr_prod;
   logic [8:0]             yoe5_in, yoe5_ff;
   logic [REMM_BITS+MB_SC-1:0] sc_prod;
   tod_type                tod5_in, tod5_ff;

   // Stage 6: first day of that year within the cycle.
   logic [ERA_BITS-1:0]    era6_ff;
   logic [DOE_BITS-1:0]    doe6_ff;
   logic [8:0]             yoe6_ff;
   logic [9+MB_YC-1:0]     yc_prod;
   logic [DOE_BITS-1:0]    yd6_in, yd6_ff;
   tod_type                tod6_ff;

   // Stage 7: day of year.
   logic [ERA_BITS-1:0]    era7_ff;
   logic [8:0]             yoe7_ff;
   logic [8:0]             doy7_in, doy7_ff;
   tod_type                tod7_ff;

   // Stage 8: month of the March-based year.
   logic [ERA_BITS-1:0]    era8_ff;
   logic [8:0]             yoe8_ff;
   logic [8:0]             doy8_ff;
   logic [10:0]            mp_num;
   logic [11+MB_MP-1:0]    mp_prod;
   logic [3:0]             mp8_in, mp8_ff;
   tod_type                tod8_ff;

   // Stage 9: output register.
   logic                   bump;
   logic [YFB-1:0]         year_full;
   rsp_type                rsp_in, rsp_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-2:0], accept};
      end
   end

   // Stage 1.
   assign z1_in    = ZB'(req_data.day_number) + ZB'(EPOCH_OFFSET);
   assign era_prod = (ZB+MB_ERA)'(z1_in) * (ZB+MB_ERA)'(M_ERA);
   assign era1_in  = ERA_BITS'(era_prod >> S_ERA);
   assign hr_prod  = (TICK_BITS+MB_HR)'(req_data.tick_of_day) * (TICK_BITS+MB_HR)'(M_HR);
   assign hr1_in   = 5'(hr_prod >> S_HR);
   assign ok1_in   = req_data.tick_of_day < TICK_BITS'(TICKS_PER_DAY);

   // Stage 2.
   assign doe2_in = DOE_BITS'(z1_ff - ZB'(ZB'(era1_ff) * ZB'(ERA_DAYS)));
   assign rem2_in = REMH_BITS'(tk1_ff - TICK_BITS'(TICK_BITS'(hr1_ff) *
                                                   TICK_BITS'(TICKS_PER_HOUR)));

   // Stage 3.
   assign q4_prod   = (DOE_BITS+MB_Q4)'(doe2_ff) * (DOE_BITS+MB_Q4)'(M_Q4);
   assign q4_3_in   = 7'(q4_prod >> S_Q4);
   assign c1_prod   = (DOE_BITS+MB_C1)'(doe2_ff) * (DOE_BITS+MB_C1)'(M_C1);
   assign c1_3_in   = 3'(c1_prod >> S_C1);
   assign last3_in  = doe2_ff == DOE_BITS'(ERA_LAST_DAY);
   assign mn_prod   = (REMH_BITS+MB_MN)'(rem2_ff) * (REMH_BITS+MB_MN)'(M_MN);
   assign mn3_in    = 6'(mn_prod >> S_MN);

   // Stage 4.
   assign yn4_in  = doe3_ff - DOE_BITS'(q4_3_ff) + DOE_BITS'(c1_3_ff) - DOE_BITS'(last3_ff);
   assign rem4_in = REMM_BITS'(rem3_ff - REMH_BITS'(REMH_BITS'(mn3_ff) *
                                                   REMH_BITS'(TICKS_PER_MIN)));

   // Stage 5.
   assign yr_prod = (DOE_BITS+MB_YR)'(yn4_ff) * (DOE_BITS+MB_YR)'(M_YR);
   assign yoe5_in = 9'(yr_prod >> S_YR);
   assign sc_prod = (REMM_BITS+MB_SC)'(rem4_ff) * (REMM_BITS+MB_SC)'(M_SC);

   always_comb begin
      tod5_in.ok = ok4_ff;
      if (ok4_ff) begin
         tod5_in.hour   = hr4_ff;
         tod5_in.minute = mn4_ff;
         tod5_in.second = 6'(sc_prod >> S_SC);
      end else begin
         tod5_in.hour   = '0;
         tod5_in.minute = '0;
         tod5_in.second = '0;
      end
   end

   // Stage 6.
   assign yc_prod = (9+MB_YC)'(yoe5_ff) * (9+MB_YC)'(M_YC);
   assign yd6_in  = DOE_BITS'(DOE_BITS'(yoe5_ff) * DOE_BITS'(YEAR_DAYS))
                    + DOE_BITS'(yoe5_ff >> 2)
                    - DOE_BITS'(yc_prod >> S_YC);

   // Stage 7.
   assign doy7_in = 9'(doe6_ff - yd6_ff);

   // Stage 8.
   assign mp_num  = 11'(doy7_ff) * 11'(MONTH_SCALE) + 11'(MONTH_ROUND);
   assign mp_prod = (11+MB_MP)'(mp_num) * (11+MB_MP)'(M_MP);
   assign mp8_in  = 4'(mp_prod >> S_MP);

   // Stage 9: January and February belong to the next calendar year.
   assign bump      = mp8_ff >= 4'(MP_JANUARY);
   assign year_full = YFB'(yoe8_ff) + YFB'(era8_ff) * YFB'(CYCLE_YEARS)
                      + YFB'(BASE_YEAR) + YFB'(bump);

   always_comb begin
      rsp_in.year         = 12'(year_full);
      rsp_in.month        = bump ? mp8_ff - 4'(JANUARY_SHIFT) : mp8_ff + 4'(MARCH_NUMBER);
      rsp_in.day_of_month = 5'(doy8_ff - month_start(mp8_ff) + 9'd1);
      rsp_in.hour         = tod8_ff.hour;
      rsp_in.minute       = tod8_ff.minute;
      rsp_in.second       = tod8_ff.second;
      rsp_in.valid_res    = tod8_ff.ok;
   end

   always_ff @(posedge clock) begin
      z1_ff    <= z1_in;
      era1_ff  <= era1_in;
      tk1_ff   <= req_data.tick_of_day;
      hr1_ff   <= hr1_in;
      ok1_ff   <= ok1_in;

      era2_ff  <= era1_ff;
      doe2_ff  <= doe2_in;
      hr2_ff   <= hr1_ff;
      rem2_ff  <= rem2_in;
      ok2_ff   <= ok1_ff;

      era3_ff  <= era2_ff;
      doe3_ff  <= doe2_ff;
      q4_3_ff  <= q4_3_in;
      c1_3_ff  <= c1_3_in;
      last3_ff <= last3_in;
      hr3_ff   <= hr2_ff;
      rem3_ff  <= rem2_ff;
      mn3_ff   <= mn3_in;
      ok3_ff   <= ok2_ff;

      era4_ff  <= era3_ff;
      doe4_ff  <= doe3_ff;
      yn4_ff   <= yn4_in;
      hr4_ff   <= hr3_ff;
      mn4_ff   <= mn3_ff;
      rem4_ff  <= rem4_in;
      ok4_ff   <= ok3_ff;

      era5_ff  <= era4_ff;
      doe5_ff  <= doe4_ff;
      yoe5_ff  <= yoe5_in;
      tod5_ff  <= tod5_in;

      era6_ff  <= era5_ff;
      doe6_ff  <= doe5_ff;
      yoe6_ff  <= yoe5_ff;
      yd6_ff   <= yd6_in;
      tod6_ff  <= tod5_ff;

      era7_ff  <= era6_ff;
      yoe7_ff  <= yoe6_ff;
      doy7_ff  <= doy7_in;
      tod7_ff  <= tod6_ff;

      era8_ff  <= era7_ff;
      yoe8_ff  <= yoe7_ff;
      doy8_ff  <= doy7_ff;
      mp8_ff   <= mp8_in;
      tod8_ff  <= tod7_ff;

      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = vld_ff[NSTG-1];
   assign rsp_data   = rsp_ff;

`ifndef SYNTH
   // Every transfer comes out with rsp_strobe once it has passed the whole pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##9 rsp_strobe)
      else $error("result missing nine cycles after a transfer");

   // The reciprocal cycle estimate must leave a day of cycle in range.
   a_doe_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> doe2_ff < DOE_BITS'(ERA_DAYS))
      else $error("day of cycle out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.month >= 4'd1) && (rsp_data.month <= 4'd12) &&
                     (rsp_data.day_of_month >= 5'd1))
      else $error("month or day of month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.valid_res |->
         (rsp_data.hour <= 5'd23) && (rsp_data.minute <= 6'd59) &&
         (rsp_data.second <= 6'd59))
      else $error("time of day field out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.valid_res |->
         (rsp_data.hour == 5'd0) && (rsp_data.minute == 6'd0) &&
         (rsp_data.second == 6'd0))
      else $error("time fields not cleared for an out of range tick count");
`endif

endmodule

[test/tb_day_serial_to_calendar_fields.sv]
// Testbench for day_serial_to_calendar_fields: directed and random day numbers and tick counts.
// It predicts each calendar result itself and checks it against the strobed output.
// Depends on dsc_pkg for the transfer structs and the calendar and time of day constants.
module tb_day_serial_to_calendar_fields
   import dsc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned EPOCH_YEAR   = 1900;
   localparam int unsigned LAST_DAY     = (1 << DAY_BITS) - 1;
   localparam int unsigned LAST_TICK    = (1 << TICK_BITS) - 1;
   localparam int unsigned LAST_YEAR_IX = 358;
   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct packed {
      req_type    data;
      logic [6:0] gap_pct;
   } pending_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pending_type pending_reqs[$];
   rsp_type     expected_fields[$];
   int          error_count = 0;

   day_serial_to_calendar_fields uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
   endfunction

   function automatic int unsigned leap_years_through(input int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   // Day number of January 1 of year EPOCH_YEAR + yr_ix.
   function automatic int unsigned year_first_day(input int unsigned yr_ix);
      return YEAR_DAYS * yr_ix + leap_years_through(EPOCH_YEAR - 1 + yr_ix)
             - leap_years_through(EPOCH_YEAR - 1);
   endfunction

   function automatic int unsigned month_length(input int unsigned mon, input bit leap);
      int unsigned len;
      case (mon)
         1:          len = leap ? 29 : 28;
         3, 5, 8, 10: len = 30;
         default:    len = 31;
      endcase
      return len;
   endfunction

   function automatic rsp_type calendar_of(input req_type r);
      int unsigned days, yr_ix, rem, mon, ticks, len;
      bit          leap, found;
      rsp_type     f;
      days  = 32'(r.day_number);
      yr_ix = days * CYCLE_YEARS / ERA_DAYS;
      // The estimate can be off by one either way near a year start.
      while (yr_ix > 0 && year_first_day(yr_ix) > days)
         yr_ix--;
      while (year_first_day(yr_ix + 1) <= days)
         yr_ix++;
      rem   = days - year_first_day(yr_ix);
      leap  = is_leap_year(EPOCH_YEAR + yr_ix);
      mon   = 0;
      found = 1'b0;
      for (int m = 0; m < 12; m++) begin
         if (!found) begin
            mon = m;
            len = month_length(m, leap);
            if (rem < len)
               found = 1'b1;
            else
               rem -= len;
         end
      end
      f              = '0;
      f.year         = 12'(EPOCH_YEAR + yr_ix);
      f.month        = 4'(mon + 1);
      f.day_of_month = 5'(rem + 1);
      ticks          = 32'(r.tick_of_day);
      if (ticks < TICKS_PER_DAY) begin
         f.valid_res = 1'b1;
         f.hour      = 5'(ticks / TICKS_PER_HOUR);
         ticks       = ticks % TICKS_PER_HOUR;
         f.minute    = 6'(ticks / TICKS_PER_MIN);
         ticks       = ticks % TICKS_PER_MIN;
         f.second    = 6'(ticks / TICKS_PER_SEC);
      end
      return f;
   endfunction

   task automatic add_item(input int unsigned day, input int unsigned tick,
                           input int unsigned gap);
      pending_type p;
      p.data.day_number  = DAY_BITS'(day);
      p.data.tick_of_day = TICK_BITS'(tick);
      p.gap_pct          = 7'(gap);
      pending_reqs.push_back(p);
   endtask

   task automatic add_random_item(input int unsigned gap);
      int unsigned day, tick, pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // Land on or next to a year start or the end of February.
         day = year_first_day($urandom_range(0, LAST_YEAR_IX));
         case ($urandom_range(0, 5))
            0:       day = day + 58;
            1:       day = day + 59;
            2:       day = day + 60;
            3:       day = (day > 0) ? day - 1 : day;
            4:       day = day + 365;
            default: day = day;
         endcase
         if (day > LAST_DAY)
            day = LAST_DAY;
      end else begin
         day = $urandom_range(0, LAST_DAY);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80)
         tick = $urandom_range(0, TICKS_PER_DAY - 1);
      else if (pick < 90)
         tick = $urandom_range(TICKS_PER_DAY, LAST_TICK);
      else
         tick = $urandom_range(0, LAST_TICK);
      add_item(day, tick, gap);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Driver: a transfer happens at an edge where start is high and busy is low.
   always @(posedge clock) begin : drive
      pending_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_fields.push_back(calendar_of(req_data));
         if (start && busy) begin
            // Hold the item until it is taken.
         end else if (pending_reqs.size() > 0 &&
                      $urandom_range(0, 99) >= 32'(pending_reqs[0].gap_pct)) begin
            nxt = pending_reqs.pop_front();
            start    <= 1'b1;
            req_data <= nxt.data;
         end else begin
            start    <= 1'b0;
            req_data <= $bits(req_type)'({$urandom, $urandom});
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_fields.size() == 0) begin
            $error("result with no transfer pending: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_fields.pop_front();
            check_field("year", 32'(want.year), 32'(rsp_data.year));
            check_field("month", 32'(want.month), 32'(rsp_data.month));
            check_field("day_of_month", 32'(want.day_of_month),
                        32'(rsp_data.day_of_month));
            check_field("hour", 32'(want.hour), 32'(rsp_data.hour));
            check_field("minute", 32'(want.minute), 32'(rsp_data.minute));
            check_field("second", 32'(want.second), 32'(rsp_data.second));
            check_field("valid_res", 32'(want.valid_res), 32'(rsp_data.valid_res));
         end
      end
   end

   initial begin
      clock    = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      // Directed part: field extremes, leap and century rules, tick limits.
      add_item(0, 0, 9);
      add_item(58, TICKS_PER_DAY - 1, 9);
      add_item(59, TICKS_PER_DAY, 9);
      add_item(364, LAST_TICK, 9);
      add_item(365, TICKS_PER_HOUR - 1, 9);
      add_item(36524, TICKS_PER_HOUR, 9);
      add_item(36582, TICKS_PER_MIN - 1, 9);
      add_item(36583, TICKS_PER_MIN, 9);
      add_item(36584, TICKS_PER_SEC - 1, 9);
      add_item(36889, TICKS_PER_SEC, 9);
      add_item(38044, 12345678, 9);
      add_item(38045, TICKS_PER_DAY + 1, 9);
      add_item(73107, 0, 9);
      add_item(73108, 1, 9);
      add_item(1 << (DAY_BITS - 1), 1 << (TICK_BITS - 1), 9);
      add_item(LAST_DAY - 1, TICKS_PER_DAY - TICKS_PER_SEC, 9);
      add_item(LAST_DAY, LAST_TICK, 0);
      add_item(LAST_DAY, 0, 0);

      // Random part in three idling phases.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS * 7 / 20)
            add_random_item(9);
         else if (i < RANDOM_ITEMS * 7 / 10)
            add_random_item(70);
         else
            add_random_item(0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || start)
         @(posedge clock);
      while (expected_fields.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #200000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[day_serial_to_calendar_fields.f]
hdl/dsc_pkg.sv
hdl/day_serial_to_calendar_fields.sv
test/tb_day_serial_to_calendar_fields.sv
